>>> src/prrs_pkg.sv
// Shared types and constants of the pose record and replay sequencer.
// No dependencies; imported by the top level.
package prrs_pkg;

  // Pose store geometry
  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int ANGLE_W = 8;
  localparam int TIME_W  = 32;
  localparam int LIMIT_W = 7;
  localparam int IVAL_W  = 16;
  localparam int SLOT_W  = 7;
  localparam int KIND_W  = 2;
  localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  // Stream and configuration port widths
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_RECORD_LIMIT  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_INTERVAL = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GRIP_OPEN     = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_GRIP_CLOSED   = 2'd3;

  // Request kinds
  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_REPLAY = 1'b1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_RECORDED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STEP     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE     = 2'd3;

  // Reset values of the configuration registers
  localparam logic [LIMIT_W-1:0] RST_RECORD_LIMIT  = 7'd50;
  localparam logic [IVAL_W-1:0]  RST_STEP_INTERVAL = 16'd2000;
  localparam logic [ANGLE_W-1:0] RST_GRIP_OPEN     = 8'd70;
  localparam logic [ANGLE_W-1:0] RST_GRIP_CLOSED   = 8'd160;

  // One stored pose
  typedef struct packed {
    logic               grip_open;
    logic [ANGLE_W-1:0] joint_d;
    logic [ANGLE_W-1:0] joint_c;
    logic [ANGLE_W-1:0] joint_b;
    logic [ANGLE_W-1:0] joint_a;
  } pose_t;

endpackage

>>> src/pose_record_replay_sequencer.sv
// Top level of the pose record and replay sequencer: pose store, replay timer,
// result register. Depends on prrs_pkg.
//
// Teach-and-replay store for a four-joint arm with a gripper. A record item
// (in_tuser = 0) writes its four joint angles and gripper bit into the next
// slot of a 64-entry pose memory and answers "recorded" with the new count,
// or "full" with the held count once min(record_limit, 64) slots are used.
// A replay item (in_tuser = 1) carries the millisecond time. The first one
// while poses are held arms replay and latches the time; later items emit the
// next pose once strictly more than step_interval_ms have passed (wrap-safe
// 32-bit difference), with the gripper bit mapped to the open or closed angle.
// A replay item past the last pose answers "complete" and disarms; the next
// replay item starts over from the first pose. Items that cause no result
// (idle poll, start, interval not yet exceeded) leave nothing on the output.
// Rate: one item per cycle while no result stalls. All decisions are made in
// the cycle an item is accepted; the single result register (which also
// holds the registered read data of the pose memory) decouples the output,
// so in_tready stays high unless a result waits while out_tready is low.
// The pose memory has no reset; only the count, replay pointer, flags and
// time stamp are cleared, so no clearing pass is needed.
module pose_record_replay_sequencer
  import prrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // request stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // in_tdata, lowest bit up: joint_a[7:0], joint_b[15:8], joint_c[23:16],
  // joint_d[31:24], grip_open[32], now_ms[64:33], zero pad[71:65]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: req_type[0]
  input  logic                  in_tuser,
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata, lowest bit up: slot_number[6:0], out_joint_a[14:7],
  // out_joint_b[22:15], out_joint_c[30:23], out_joint_d[38:31],
  // gripper_angle[46:39], zero pad[47]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // out_tuser: result_kind[1:0]
  output logic [KIND_W-1:0]     out_tuser
);

  // Configuration registers
  logic [LIMIT_W-1:0] record_limit_r;
  logic [IVAL_W-1:0]  step_interval_r;
  logic [ANGLE_W-1:0] grip_open_angle_r;
  logic [ANGLE_W-1:0] grip_closed_angle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_limit_r      <= RST_RECORD_LIMIT;
      step_interval_r     <= RST_STEP_INTERVAL;
      grip_open_angle_r   <= RST_GRIP_OPEN;
      grip_closed_angle_r <= RST_GRIP_CLOSED;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RECORD_LIMIT:  record_limit_r      <= cfg_wdata[LIMIT_W-1:0];
        REG_STEP_INTERVAL: step_interval_r     <= cfg_wdata[IVAL_W-1:0];
        REG_GRIP_OPEN:     grip_open_angle_r   <= cfg_wdata[ANGLE_W-1:0];
        REG_GRIP_CLOSED:   grip_closed_angle_r <= cfg_wdata[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the request
  logic                req_type;
  pose_t               in_pose;
  logic [TIME_W-1:0]   now_ms;

  assign req_type          = in_tuser;
  assign in_pose.joint_a   = in_tdata[7:0];
  assign in_pose.joint_b   = in_tdata[15:8];
  assign in_pose.joint_c   = in_tdata[23:16];
  assign in_pose.joint_d   = in_tdata[31:24];
  assign in_pose.grip_open = in_tdata[32];
  assign now_ms            = in_tdata[64:33];

  // Sequencer state
  logic [CNT_W-1:0]  pose_count_r, pose_count_nxt;
  logic              replay_active_r, replay_active_nxt;
  logic [CNT_W-1:0]  replay_index_r, replay_index_nxt;
  logic [TIME_W-1:0] last_step_time_r, last_step_time_nxt;

  // Result register
  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [SLOT_W-1:0] out_slot_r;
  pose_t             rd_pose_r;

  logic in_accept;
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  // Per-item decision
  logic [CMP_W-1:0]  limit_eff;
  logic [CMP_W-1:0]  count_ext;
  logic              start_now;
  logic [CNT_W-1:0]  index_eff;
  logic [TIME_W-1:0] last_eff;
  logic [TIME_W-1:0] elapsed;
  logic              res_valid;
  logic [KIND_W-1:0] res_kind;
  logic [SLOT_W-1:0] res_slot;
  logic              wr_en;
  logic              rd_en;

  always_comb begin
    // clamp the limit to the store depth
    if (CMP_W'(record_limit_r) > CMP_W'(TABLE_DEPTH)) begin
      limit_eff = CMP_W'(TABLE_DEPTH);
    end else begin
      limit_eff = CMP_W'(record_limit_r);
    end
    count_ext = CMP_W'(pose_count_r);

    // a poll while disarmed with poses held arms replay at this time
    start_now = !replay_active_r && (pose_count_r != '0);
    index_eff = start_now ? '0 : replay_index_r;
    last_eff  = start_now ? now_ms : last_step_time_r;
    elapsed   = now_ms - last_eff;

    pose_count_nxt     = pose_count_r;
    replay_active_nxt  = replay_active_r;
    replay_index_nxt   = replay_index_r;
    last_step_time_nxt = last_step_time_r;
    res_valid          = 1'b0;
    res_kind           = KIND_RECORDED;
    res_slot           = '0;
    wr_en              = 1'b0;
    rd_en              = 1'b0;

    if (req_type == REQ_RECORD) begin
      res_valid = 1'b1;
      if (count_ext >= limit_eff) begin
        res_kind = KIND_FULL;
        res_slot = SLOT_W'(pose_count_r);
      end else begin
        wr_en          = 1'b1;
        pose_count_nxt = pose_count_r + CNT_W'(1);
        res_kind       = KIND_RECORDED;
        res_slot       = SLOT_W'(pose_count_nxt);
      end
    end else if (replay_active_r || start_now) begin
      replay_active_nxt  = 1'b1;
      replay_index_nxt   = index_eff;
      last_step_time_nxt = last_eff;
      if (elapsed > TIME_W'(step_interval_r)) begin
        res_valid = 1'b1;
        if (index_eff < pose_count_r) begin
          // emit the next pose and restart the interval
          rd_en              = 1'b1;
          replay_index_nxt   = index_eff + CNT_W'(1);
          last_step_time_nxt = now_ms;
          res_kind           = KIND_STEP;
          res_slot           = SLOT_W'(replay_index_nxt);
        end else begin
          // past the last pose: report and disarm
          replay_active_nxt = 1'b0;
          res_kind          = KIND_DONE;
          res_slot          = SLOT_W'(index_eff);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_count_r     <= '0;
      replay_active_r  <= 1'b0;
      replay_index_r   <= '0;
      last_step_time_r <= '0;
    end else if (in_accept) begin
      pose_count_r     <= pose_count_nxt;
      replay_active_r  <= replay_active_nxt;
      replay_index_r   <= replay_index_nxt;
      last_step_time_r <= last_step_time_nxt;
    end
  end

  // Pose memory: one write port, one registered read port
  pose_t pose_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (in_accept && wr_en) begin
      pose_mem[pose_count_r[ADDR_W-1:0]] <= in_pose;
    end
  end

  // read data lands in the result register; hold it while a result stalls
  always_ff @(posedge clk) begin
    if (in_accept && rd_en) begin
      rd_pose_r <= pose_mem[index_eff[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && res_valid) begin
      out_kind_r <= res_kind;
      out_slot_r <= res_slot;
    end
  end

  // Output formatting: pose fields only on a step, zero otherwise
  logic               is_step;
  logic [ANGLE_W-1:0] grip_angle;
  pose_t              out_pose;

  assign is_step    = (out_kind_r == KIND_STEP);
  assign out_pose   = is_step ? rd_pose_r : '0;
  assign grip_angle = !is_step            ? '0 :
                      rd_pose_r.grip_open ? grip_open_angle_r : grip_closed_angle_r;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {1'b0, grip_angle, out_pose.joint_d, out_pose.joint_c,
                       out_pose.joint_b, out_pose.joint_a, out_slot_r};

endmodule

>>> verif/pose_sequencer_checker.sv
`timescale 1ns / 1ps
// Checker for pose_record_replay_sequencer: snoops register writes and both
// streams, predicts each result and compares it field by field.
// Depends on prrs_pkg.
module pose_sequencer_checker
  import prrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [KIND_W-1:0]     out_tuser,
  output int                    mismatch_count,
  output int                    answers_due
);

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [SLOT_W-1:0]  slot;
    logic [ANGLE_W-1:0] joint_a;
    logic [ANGLE_W-1:0] joint_b;
    logic [ANGLE_W-1:0] joint_c;
    logic [ANGLE_W-1:0] joint_d;
    logic [ANGLE_W-1:0] grip;
  } arm_answer_t;

  pose_t              taught_poses [TABLE_DEPTH];
  int unsigned        poses_held;
  int unsigned        steps_played;
  logic               replaying;
  logic [TIME_W-1:0]  last_step_ms;
  logic [LIMIT_W-1:0] limit_reg;
  logic [IVAL_W-1:0]  interval_reg;
  logic [ANGLE_W-1:0] open_reg;
  logic [ANGLE_W-1:0] closed_reg;
  arm_answer_t        due_answers [$];
  int                 fails = 0;
  int                 due_count = 0;

  assign mismatch_count = fails;
  assign answers_due    = due_count;

  task automatic report_mismatch(input string msg);
    fails++;
    if (fails <= 40) $display("%0t: mismatch: %s", $time, msg);
  endtask

  // Work out what one accepted request answers, if anything.
  task automatic teach_or_replay(input logic req, input pose_t pose,
                                 input logic [TIME_W-1:0] now_ms);
    arm_answer_t       ans;
    int unsigned       cap;
    logic [TIME_W-1:0] elapsed;
    pose_t             played;
    ans = '0;
    if (req == REQ_RECORD) begin
      cap = (limit_reg > TABLE_DEPTH) ? TABLE_DEPTH : limit_reg;
      if (poses_held >= cap) begin
        ans.kind = KIND_FULL;
      end else begin
        taught_poses[poses_held] = pose;
        poses_held++;
        ans.kind = KIND_RECORDED;
      end
      ans.slot = SLOT_W'(poses_held);
      due_answers.push_back(ans);
    end else begin
      // arm on the first poll while poses are held; zero time has passed then
      if (!replaying && poses_held != 0) begin
        replaying    = 1'b1;
        steps_played = 0;
        last_step_ms = now_ms;
      end
      elapsed = now_ms - last_step_ms;
      if (replaying && elapsed > TIME_W'(interval_reg)) begin
        if (steps_played < poses_held) begin
          played = taught_poses[steps_played];
          steps_played++;
          last_step_ms = now_ms;
          ans.kind    = KIND_STEP;
          ans.joint_a = played.joint_a;
          ans.joint_b = played.joint_b;
          ans.joint_c = played.joint_c;
          ans.joint_d = played.joint_d;
          ans.grip    = played.grip_open ? open_reg : closed_reg;
        end else begin
          replaying = 1'b0;
          ans.kind  = KIND_DONE;
        end
        ans.slot = SLOT_W'(steps_played);
        due_answers.push_back(ans);
      end
    end
  endtask

  task automatic check_answer(input logic [KIND_W-1:0] kind,
                              input logic [OUT_DATA_W-1:0] data);
    arm_answer_t want;
    if (due_answers.size() == 0) begin
      report_mismatch($sformatf("result of kind %0d with none due", kind));
    end else begin
      want = due_answers.pop_front();
      if (kind != want.kind)
        report_mismatch($sformatf("result kind %0d, expected %0d", kind, want.kind));
      if (data[6:0] != want.slot)
        report_mismatch($sformatf("slot %0d, expected %0d", data[6:0], want.slot));
      if (data[14:7] != want.joint_a)
        report_mismatch($sformatf("joint a %0d, expected %0d", data[14:7], want.joint_a));
      if (data[22:15] != want.joint_b)
        report_mismatch($sformatf("joint b %0d, expected %0d", data[22:15], want.joint_b));
      if (data[30:23] != want.joint_c)
        report_mismatch($sformatf("joint c %0d, expected %0d", data[30:23], want.joint_c));
      if (data[38:31] != want.joint_d)
        report_mismatch($sformatf("joint d %0d, expected %0d", data[38:31], want.joint_d));
      if (data[46:39] != want.grip)
        report_mismatch($sformatf("gripper %0d, expected %0d", data[46:39], want.grip));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      poses_held   = 0;
      steps_played = 0;
      replaying    = 1'b0;
      last_step_ms = '0;
      limit_reg    = RST_RECORD_LIMIT;
      interval_reg = RST_STEP_INTERVAL;
      open_reg     = RST_GRIP_OPEN;
      closed_reg   = RST_GRIP_CLOSED;
      due_answers.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_RECORD_LIMIT:  limit_reg    = cfg_wdata[LIMIT_W-1:0];
          REG_STEP_INTERVAL: interval_reg = cfg_wdata[IVAL_W-1:0];
          REG_GRIP_OPEN:     open_reg     = cfg_wdata[ANGLE_W-1:0];
          REG_GRIP_CLOSED:   closed_reg   = cfg_wdata[ANGLE_W-1:0];
          default: ;
        endcase
      end
      // compare before predicting: a result never belongs to the item
      // accepted at the same edge
      if (out_tvalid && out_tready) check_answer(out_tuser, out_tdata);
      if (in_tvalid && in_tready)
        teach_or_replay(in_tuser, pose_t'(in_tdata[32:0]), in_tdata[64:33]);
    end
    due_count = due_answers.size();
  end

endmodule

>>> verif/tb_pose_record_replay_sequencer.sv
`timescale 1ns / 1ps
// Testbench top for pose_record_replay_sequencer: clock, reset, request and
// result stream drivers, register writes, watchdog and verdict.
// Depends on prrs_pkg, the block and pose_sequencer_checker.
module tb_pose_record_replay_sequencer;
  import prrs_pkg::*;

  localparam int QUIET_LIMIT     = 2000;  // idle cycles before giving up
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 150;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  // in_tdata, lowest bit up: joint_a, joint_b, joint_c, joint_d,
  // grip_open, now_ms, zero pad
  logic [IN_DATA_W-1:0]  in_tdata;
  // in_tuser: req_type
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  // out_tdata, lowest bit up: slot_number, out_joint_a, out_joint_b,
  // out_joint_c, out_joint_d, gripper_angle, zero pad
  logic [OUT_DATA_W-1:0] out_tdata;
  // out_tuser: result_kind
  logic [KIND_W-1:0]     out_tuser;

  int                    mismatch_count;
  int                    answers_due;
  int unsigned           quiet_cycles = 0;
  int unsigned           stall_left = 0;
  logic                  idle_on;       // random gaps and stalls when set
  logic [TIME_W-1:0]     wall_ms;       // millisecond clock fed to replay polls
  logic [IVAL_W-1:0]     step_gap_ms;   // interval currently programmed

  pose_record_replay_sequencer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  pose_sequencer_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .mismatch_count (mismatch_count),
    .answers_due    (answers_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly no gap, sometimes a few cycles, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 70) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Favor the ends of the angle range now and then.
  function automatic logic [ANGLE_W-1:0] pick_angle();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd180;
      default: return ANGLE_W'($urandom_range(0, 180));
    endcase
  endfunction

  function automatic pose_t make_pose(input int a, input int b, input int c,
                                      input int d, input logic g);
    pose_t p;
    p.joint_a   = ANGLE_W'(a);
    p.joint_b   = ANGLE_W'(b);
    p.joint_c   = ANGLE_W'(c);
    p.joint_d   = ANGLE_W'(d);
    p.grip_open = g;
    return p;
  endfunction

  function automatic pose_t random_pose();
    return make_pose(pick_angle(), pick_angle(), pick_angle(), pick_angle(),
                     1'($urandom_range(0, 1)));
  endfunction

  // Advance the millisecond clock: mostly just past the interval, sometimes
  // short of it or exactly on it, sometimes a random jump that may wrap.
  function automatic logic [TIME_W-1:0] next_time(input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] ival;
    ival = TIME_W'(step_gap_ms);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return t + ival + 1 + $urandom_range(0, 3);
      4, 5:       return t + TIME_W'($urandom_range(0, int'(step_gap_ms)));
      6:          return t + ival;
      7:          return t;
      8:          return t + ival + 1;
      default:    return t + TIME_W'($urandom);
    endcase
  endfunction

  // Present one item at the falling edge and hold it until accepted. Valid
  // only drops when a gap follows, so it never toggles twice in one step.
  task automatic send_item(input logic req, input pose_t p,
                           input logic [TIME_W-1:0] now_ms);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {7'd0, now_ms, p};
    do @(posedge clk); while (!in_tready);
  endtask

  // The time field is ignored on a record; randomize it anyway.
  task automatic record_pose(input pose_t p);
    send_item(REQ_RECORD, p, $urandom);
  endtask

  task automatic poll_replay(input logic [TIME_W-1:0] now_ms);
    send_item(REQ_REPLAY, random_pose(), now_ms);
  endtask

  // Drain the block, give it a few cycles for polls that answer nothing,
  // then program all four registers back to back.
  task automatic load_settings(input logic [LIMIT_W-1:0] lim,
                               input logic [IVAL_W-1:0] ival,
                               input logic [ANGLE_W-1:0] open_deg,
                               input logic [ANGLE_W-1:0] closed_deg);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (answers_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_RECORD_LIMIT;
    cfg_wdata <= CFG_DATA_W'(lim);
    @(negedge clk);
    cfg_addr  <= REG_STEP_INTERVAL;
    cfg_wdata <= CFG_DATA_W'(ival);
    @(negedge clk);
    cfg_addr  <= REG_GRIP_OPEN;
    cfg_wdata <= CFG_DATA_W'(open_deg);
    @(negedge clk);
    cfg_addr  <= REG_GRIP_CLOSED;
    cfg_wdata <= CFG_DATA_W'(closed_deg);
    @(negedge clk);
    cfg_we    <= 1'b0;
    step_gap_ms = ival;
  endtask

  // Result side: ready by default, stalls of random length when idling is on.
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 4) == 0) stall_left = pick_gap();
      end
    end
  end

  // Count cycles in which nothing moves on any port.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("pose_record_replay_sequencer test failed");
    $finish;
  end

  initial begin
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_wdata   = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = REQ_RECORD;
    idle_on     = 1'b1;
    wall_ms     = '0;
    step_gap_ms = RST_STEP_INTERVAL;
    rst_n       = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings (limit 50, 2000 ms, 70 / 160).
    poll_replay(32'd100);                       // no poses held: ignored
    record_pose(make_pose(0, 0, 0, 0, 1'b0));   // lowest angles, closed
    record_pose(make_pose(180, 180, 180, 180, 1'b1));
    poll_replay(32'd1000);                      // arm replay, latch time
    poll_replay(32'd3000);                      // exactly the interval: hold
    poll_replay(32'd3001);                      // first step
    record_pose(random_pose());                 // record while replaying
    poll_replay(32'd5002);
    poll_replay(32'd7003);                      // plays the pose added above
    poll_replay(32'd9004);                      // past the end: complete
    poll_replay(32'd9005);                      // rearm from the first pose

    // Limit of zero refuses everything; step across the 32-bit wrap.
    load_settings(7'd0, 16'd500, 8'd0, 8'd180);
    record_pose(random_pose());
    poll_replay(32'd9505);                      // interval not exceeded
    poll_replay(32'd9506);
    poll_replay(32'hFFFF_FF00);
    poll_replay(32'h0000_00F4);                 // 500 ms across the wrap: hold
    poll_replay(32'h0000_00F5);
    poll_replay(32'h0000_0400);                 // complete

    // Limits above the table depth clamp to it.
    load_settings(7'd127, 16'hFFFF, 8'd180, 8'd70);
    record_pose(random_pose());

    // Random phases, each under its own settings; every third runs flat out.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: load_settings(7'd1, 16'd0, 8'd180, 8'd0);
        1: load_settings(7'd10, 16'hFFFF, 8'd0, 8'd0);
        2: load_settings(7'd30, 16'd1, 8'd180, 8'd180);
        3: load_settings(7'd64, 16'd40, 8'd70, 8'd160);
        default: load_settings(LIMIT_W'($urandom_range(0, 127)),
                               ($urandom_range(0, 3) == 0) ?
                                 IVAL_W'($urandom_range(0, 65535)) :
                                 IVAL_W'($urandom_range(0, 300)),
                               ANGLE_W'($urandom_range(0, 180)),
                               ANGLE_W'($urandom_range(0, 180)));
      endcase
      idle_on = (ph % 3 != 2);
      // odd phases start just below the wrap point
      wall_ms = ph[0] ? 32'hFFFF_FFFF - $urandom_range(0, 300000) : $urandom;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < 20) begin
          record_pose(random_pose());
        end else begin
          wall_ms = next_time(wall_ms);
          poll_replay(wall_ms);
        end
      end
    end

    // Drain, then leave room for any stray result.
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (answers_due != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("pose_record_replay_sequencer test passed");
    end else begin
      $display("pose_record_replay_sequencer test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/prrs_pkg.sv
src/pose_record_replay_sequencer.sv
verif/pose_sequencer_checker.sv
verif/tb_pose_record_replay_sequencer.sv
